[hw/rtl/mkd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared constants, widths and the letters-and-digits Morse code table.
// ----------------------------------------------------------------------------
package mkd_pkg;

	// Buffer and counter dimensions.
	localparam int MAX_ELEMENTS = 7;
	localparam int COUNT_WIDTH  = 16;
	localparam int EL_CNT_W     = $clog2(MAX_ELEMENTS + 1);
	localparam int PATTERN_W    = 7;
	localparam int CHAR_W       = 7;
	localparam int REG_W        = 16;
	localparam int CFG_INDEX_W  = 8;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DOT_DASH_THRESHOLD = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_TIMEOUT     = CFG_INDEX_W'(1);

	localparam logic [REG_W-1:0] THRESHOLD_RESET = REG_W'(300);
	localparam logic [REG_W-1:0] TIMEOUT_RESET   = REG_W'(1000);

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = CHAR_W'(63);
	localparam int                CHAR_A       = 65;
	localparam int                CHAR_ZERO    = 48;

	// Table: entries 0 to 25 are A to Z, entries 26 to 35 are 0 to 9.
	localparam int NUM_LETTERS = 26;
	localparam int NUM_CODES   = 36;

	localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4,
		3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4,
		3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
		3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam logic [PATTERN_W-1:0] CODE_BITS [NUM_CODES] = '{
		7'd2,  7'd1,  7'd5,  7'd1,  7'd0,  7'd4,  7'd3,  7'd0,
		7'd0,  7'd14, 7'd5,  7'd2,  7'd3,  7'd1,  7'd7,  7'd6,
		7'd11, 7'd2,  7'd0,  7'd1,  7'd4,  7'd8,  7'd6,  7'd9,
		7'd13, 7'd3,
		7'd31, 7'd30, 7'd28, 7'd24, 7'd16,
		7'd0,  7'd1,  7'd3,  7'd7,  7'd15
	};

	// ASCII code of table entry idx.
	function automatic logic [CHAR_W-1:0] code_char(input int idx);
		logic [CHAR_W-1:0] ch;
		if (idx < NUM_LETTERS) begin
			ch = CHAR_W'(CHAR_A + idx);
		end else begin
			ch = CHAR_W'(CHAR_ZERO + idx - NUM_LETTERS);
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/morse_key_to_ascii_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key to ASCII decoder
// Turns a stream of sampled key levels into decoded letters and digits.
// ----------------------------------------------------------------------------
// Each input request carries one sampled key level (one tick). The block
// measures how long the key is held; on release the press becomes a dot if it
// was shorter than dot_dash_threshold ticks and a dash otherwise, and is added
// to a buffer of up to seven elements (later presses are dropped while the
// buffer is full). Once the key has stayed up for symbol_timeout ticks after
// the last release, the buffered pattern is looked up in the A-Z, 0-9 Morse
// table and one output request is produced with the ASCII code, or '?' with
// matched low; the buffer is then cleared. Both tick counters saturate at
// their maximum. The block takes one tick per clock cycle while its input
// side is not stalled. A tick passes an input register and then a single
// pass of counter, classification and table-match logic into the result
// register. The input side stalls only while a tick that decodes a symbol
// waits in the input register behind a result that the output side has not
// yet taken. Configuration writes are accepted in every cycle and should
// only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module morse_key_to_ascii_decoder import mkd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Tick input channel.
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   key_down,
	// Decoded symbol output channel.
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [CHAR_W-1:0]      character,
	output logic                        matched,
	output logic      [EL_CNT_W-1:0]    element_count,
	output logic      [PATTERN_W-1:0]   pattern_bits,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [REG_W-1:0] threshold_q;
	logic [REG_W-1:0] timeout_q;

	// Input register stage.
	logic valid_s1;
	logic key_s1;

	// Decoder state.
	logic                   key_was_down_q;
	logic [COUNT_WIDTH-1:0] press_ticks_q;
	logic [COUNT_WIDTH-1:0] silence_ticks_q;
	logic [PATTERN_W-1:0]   element_bits_q;
	logic [EL_CNT_W-1:0]    element_total_q;

	// Next-state values for the tick held in the input register.
	logic [COUNT_WIDTH-1:0] press_nxt;
	logic [COUNT_WIDTH-1:0] silence_nxt;
	logic [PATTERN_W-1:0]   bits_nxt;
	logic [EL_CNT_W-1:0]    total_nxt;
	logic                   fire;
	logic                   advance;
	logic                   out_free;

	logic [CHAR_W-1:0] lookup_char;
	logic              lookup_hit;

	// The configuration port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DOT_DASH_THRESHOLD) begin
				threshold_q <= cfg_data;
			end else if (cfg_index == REG_SYMBOL_TIMEOUT) begin
				timeout_q <= cfg_data;
			end
		end
	end

	// State update for one tick. A release records a dot or a dash unless the
	// buffer is full, and always restarts the silence count.
	always_comb begin
		press_nxt   = press_ticks_q;
		silence_nxt = silence_ticks_q;
		bits_nxt    = element_bits_q;
		total_nxt   = element_total_q;
		if (key_s1) begin
			if (!key_was_down_q) begin
				press_nxt = COUNT_WIDTH'(1);
			end else if (press_ticks_q != CNT_MAX) begin
				press_nxt = press_ticks_q + COUNT_WIDTH'(1);
			end
		end else if (key_was_down_q) begin
			if (element_total_q < EL_CNT_W'(MAX_ELEMENTS)) begin
				if (press_ticks_q >= COUNT_WIDTH'(threshold_q)) begin
					bits_nxt[element_total_q] = 1'b1;
				end
				total_nxt = element_total_q + EL_CNT_W'(1);
			end
			silence_nxt = '0;
		end else if (silence_ticks_q != CNT_MAX) begin
			silence_nxt = silence_ticks_q + COUNT_WIDTH'(1);
		end
	end

	// A symbol is decoded once the key is up, something is buffered and the
	// silence has lasted long enough.
	assign fire = !key_s1 && (total_nxt != '0) && (silence_nxt >= COUNT_WIDTH'(timeout_q));

	mkd_lookup u_lookup (
		.count     (total_nxt),
		.bits      (bits_nxt),
		.character (lookup_char),
		.matched   (lookup_hit)
	);

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!fire || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			key_s1 <= key_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_was_down_q  <= 1'b0;
			press_ticks_q   <= '0;
			silence_ticks_q <= '0;
			element_bits_q  <= '0;
			element_total_q <= '0;
		end else if (advance) begin
			key_was_down_q <= key_s1;
			press_ticks_q  <= press_nxt;
			if (fire) begin
				silence_ticks_q <= '0;
				element_bits_q  <= '0;
				element_total_q <= '0;
			end else begin
				silence_ticks_q <= silence_nxt;
				element_bits_q  <= bits_nxt;
				element_total_q <= total_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			character     <= lookup_char;
			matched       <= lookup_hit;
			element_count <= total_nxt;
			pattern_bits  <= bits_nxt;
		end
	end

	// The buffer never grows past its capacity.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		element_total_q <= EL_CNT_W'(MAX_ELEMENTS))
		else $error("element buffer exceeds capacity");

	// A decode empties the buffer on the next cycle.
	a_clear_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fire) |=> (element_total_q == '0 && silence_ticks_q == '0))
		else $error("buffer not cleared after decode");

	// A result always carries at least one element.
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (element_count != '0))
		else $error("result with empty pattern");

	// An unmatched pattern always reads as the unknown character.
	a_unknown_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> (character == CHAR_UNKNOWN))
		else $error("unmatched result has wrong character");

	// Pattern bits above the element count stay clear.
	a_pattern_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pattern_bits >> element_count) == '0))
		else $error("stray pattern bits above element count");

endmodule
`default_nettype wire

[hw/rtl/mkd_lookup.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Morse pattern lookup
// Matches a pattern of dots and dashes against the 36-entry code table.
// ----------------------------------------------------------------------------
module mkd_lookup import mkd_pkg::*; (
	input  wire logic [EL_CNT_W-1:0]  count,
	input  wire logic [PATTERN_W-1:0] bits,
	output logic      [CHAR_W-1:0]    character,
	output logic                      matched
);

	// Every entry is compared in parallel; entries are unique, so at most one hits.
	always_comb begin
		character = CHAR_UNKNOWN;
		matched   = 1'b0;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (3'(count) == CODE_LEN[i] && bits == CODE_BITS[i]) begin
				character = code_char(i);
				matched   = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse key to ASCII decoder testbench
// Sends sampled key levels as tick requests and checks every decoded symbol,
// field by field, against a cycle-free predictor of the decoder.
// ----------------------------------------------------------------------------
// The predictor follows each accepted tick: it measures presses and silences,
// builds the element buffer and, when the silence after the last release
// reaches the timeout, looks the pattern up in its own Morse table. The table
// is built from a dot-and-dash text so that it does not share anything with
// the package. Directed tests cover the register reset values, dot and dash
// boundaries, zero threshold and zero timeout, unmatched patterns, a full
// buffer and writes to unused register indexes.
// Random traffic then runs in several phases with different settings and
// different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench import mkd_pkg::*; ();

	// Cycles to let the two-stage pipeline empty once nothing is expected.
	localparam int SETTLE_CYCLES = 6;
	// Number of random ticks, spread over the random phases.
	localparam int RANDOM_TICKS = 1150;
	// Each random phase runs on until at least this many symbols decoded.
	localparam int MIN_PHASE_SYMBOLS = 10;
	// Longest sender gap in cycles.
	localparam int MAX_GAP = 40;

	// Register indexes that do not exist in the block.
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX   = {CFG_INDEX_W{1'b1}};

	// Character codes used by the predictor.
	localparam logic [CHAR_W-1:0] CHAR_QUESTION = 7'h3F;
	localparam byte               LETTER_BASE   = "A";
	localparam byte               DIGIT_BASE    = "0";

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	// One decoded symbol as the block reports it.
	typedef struct {
		logic [CHAR_W-1:0]    character;
		logic                 matched;
		logic [EL_CNT_W-1:0]  count;
		logic [PATTERN_W-1:0] pattern;
	} symbol_t;

	// ------------------------------------------------------------------------
	// Block ports. Every input has a known value from time zero.
	// ------------------------------------------------------------------------
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   key_down = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CHAR_W-1:0]      character;
	logic                   matched;
	logic [EL_CNT_W-1:0]    element_count;
	logic [PATTERN_W-1:0]   pattern_bits;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]       cfg_data = '0;

	// ------------------------------------------------------------------------
	// Predictor state. Register copies start at their reset values, the rest
	// at zero, exactly as the block comes out of reset.
	// ------------------------------------------------------------------------
	logic [REG_W-1:0]       dash_min = 16'd300;
	logic [REG_W-1:0]       quiet_limit = 16'd1000;
	logic                   prev_key = 1'b0;
	logic [COUNT_WIDTH-1:0] hold_ticks = '0;
	logic [COUNT_WIDTH-1:0] quiet_ticks = '0;
	logic [PATTERN_W-1:0]   elem_pattern = '0;
	logic [EL_CNT_W-1:0]    elem_count = '0;

	// Morse table of the predictor: element count and dash mask per entry,
	// letters first and digits after them.
	logic [EL_CNT_W-1:0]    code_len [NUM_CODES];
	logic [PATTERN_W-1:0]   code_pattern [NUM_CODES];

	// Symbols predicted but not yet seen at the output, oldest first.
	symbol_t symbols_due [$];

	int mismatch_count = 0;
	int ticks_sent = 0;
	int symbols_decoded = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	morse_key_to_ascii_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.key_down      (key_down),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.character     (character),
		.matched       (matched),
		.element_count (element_count),
		.pattern_bits  (pattern_bits),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The run is cut off long after the slowest correct run would end.
	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Counter step that sticks at the top value.
	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// Advances the predicted state by one tick and queues the symbol that the
	// tick decodes, if any.
	function automatic void decode_tick(input logic level);
		symbol_t sym;
		if (level) begin
			// The first down tick of a press counts as one.
			hold_ticks = prev_key ? bump(hold_ticks) : COUNT_WIDTH'(1);
		end else if (prev_key) begin
			// A release while the buffer is full is dropped, but it still
			// restarts the silence count.
			if (elem_count < MAX_ELEMENTS) begin
				if (hold_ticks >= dash_min) begin
					elem_pattern[elem_count] = 1'b1;
				end
				elem_count = elem_count + 1'b1;
			end
			quiet_ticks = '0;
		end else begin
			quiet_ticks = bump(quiet_ticks);
		end
		prev_key = level;

		if (!level && elem_count != 0 && quiet_ticks >= quiet_limit) begin
			sym.character = CHAR_QUESTION;
			sym.matched = 1'b0;
			for (int i = 0; i < NUM_CODES; i++) begin
				if (code_len[i] == elem_count && code_pattern[i] == elem_pattern) begin
					sym.matched = 1'b1;
					sym.character = (i < NUM_LETTERS) ? CHAR_W'(LETTER_BASE + i)
						: CHAR_W'(DIGIT_BASE + i - NUM_LETTERS);
				end
			end
			sym.count = elem_count;
			sym.pattern = elem_pattern;
			symbols_due.push_back(sym);
			symbols_decoded++;
			elem_pattern = '0;
			elem_count = '0;
			quiet_ticks = '0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		$display("[%0t] error: %s", $time, msg);
		mismatch_count++;
	endtask

	// Compares the symbol on the output with the oldest prediction.
	task automatic check_symbol();
		symbol_t want;
		if (symbols_due.size() == 0) begin
			flag_mismatch($sformatf("symbol with none predicted: char %0d count %0d pattern %b",
				character, element_count, pattern_bits));
		end else begin
			want = symbols_due.pop_front();
			if (character !== want.character) begin
				flag_mismatch($sformatf("character %0d, predicted %0d",
					character, want.character));
			end
			if (matched !== want.matched) begin
				flag_mismatch($sformatf("matched %b, predicted %b", matched, want.matched));
			end
			if (element_count !== want.count) begin
				flag_mismatch($sformatf("element_count %0d, predicted %0d",
					element_count, want.count));
			end
			if (pattern_bits !== want.pattern) begin
				flag_mismatch($sformatf("pattern_bits %b, predicted %b",
					pattern_bits, want.pattern));
			end
		end
	endtask

	// All handshakes are observed here, on the values that stood before the
	// edge. Outputs are checked before the tick of the same edge is predicted;
	// a tick's own symbol cannot leave the block in the cycle it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_symbol();
			end
			if (in_valid && !in_stall) begin
				decode_tick(key_down);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DOT_DASH_THRESHOLD: dash_min = cfg_data;
					REG_SYMBOL_TIMEOUT:     quiet_limit = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Receiver stalls are drawn fresh in every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic set_idling(input idling_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 72;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 72;
			end
			default: begin
				sender_idle_pct = 7;
				receiver_stall_pct = 7;
			end
		endcase
	endtask

	// Sends one tick request, after a random idle gap, and returns at the
	// edge where it is accepted. The valid line stays high from one request
	// to the next when there is no gap.
	task automatic send_tick(input logic level);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_down <= level;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ticks_sent++;
	endtask

	task automatic hold_key(input logic level, input int ticks);
		repeat (ticks) send_tick(level);
	endtask

	task automatic key_press(input int down, input int up);
		hold_key(1'b1, down);
		hold_key(1'b0, up);
	endtask

	// Keys in a pattern with random press lengths on the right side of the
	// threshold and inter-element gaps short enough not to end the symbol.
	// The silence after the last element is given by the caller.
	task automatic send_symbol(input int len, input logic [15:0] dashes, input int final_up);
		int down;
		int up;
		for (int i = 0; i < len; i++) begin
			if (dashes[i]) begin
				down = int'(dash_min) + $urandom_range(0, 2);
				if (down == 0) begin
					down = 1;
				end
			end else begin
				down = (dash_min > 1) ? $urandom_range(1, int'(dash_min) - 1) : 1;
			end
			if (i == len - 1) begin
				up = final_up;
			end else begin
				up = $urandom_range(1, (quiet_limit > 0) ? int'(quiet_limit) : 1);
			end
			key_press(down, up);
		end
	endtask

	// Holds the tick channel quiet until every predicted symbol has come out,
	// then lets the pipeline empty of ticks that decode nothing.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only ever written with the block idle.
	task automatic configure(input logic [REG_W-1:0] threshold, input logic [REG_W-1:0] timeout);
		wait_for_results();
		write_reg(REG_DOT_DASH_THRESHOLD, threshold);
		write_reg(REG_SYMBOL_TIMEOUT, timeout);
	endtask

	// Small random setting, zero and one included.
	function automatic logic [REG_W-1:0] pick_setting(input int top);
		case ($urandom_range(7))
			0: return '0;
			1: return REG_W'(1);
			default: return REG_W'($urandom_range(2, top));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// No register written yet: 299 ticks is a dot, 300 a dash, and the
	// symbol ends after 1000 silent ticks, giving A.
	task automatic test_default_registers();
		key_press(299, 5);
		key_press(300, 1001);
	endtask

	// Dot and dash boundaries, threshold zero and one (all dashes) and the
	// largest threshold (all dots).
	task automatic test_press_length();
		configure(16'd3, 16'd6);
		key_press(2, 3);
		key_press(3, 7);
		configure(16'd0, 16'd6);
		key_press(1, 2);
		key_press(1, 2);
		key_press(1, 7);
		configure(16'd1, 16'd6);
		key_press(1, 7);
		configure(16'hFFFF, 16'd6);
		key_press(5, 7);
	endtask

	// With a zero timeout each release decodes on its own tick, and the up
	// ticks after it find an empty buffer.
	task automatic test_timeout_zero();
		configure(16'd3, 16'd0);
		key_press(1, 2);
		key_press(4, 1);
		key_press(2, 3);
	endtask

	// Patterns outside the table: a four- and a five-element pattern that are
	// not codes, and six and seven elements.
	task automatic test_unmatched_patterns();
		configure(16'd3, 16'd6);
		send_symbol(4, 16'b1100, 7);
		send_symbol(5, 16'b01010, 7);
		send_symbol(6, 16'b000000, 7);
		send_symbol(7, 16'b1111111, 7);
	endtask

	// Nine presses: the last two are dropped, yet each of their releases
	// restarts the silence, so the symbol is decoded only after the ninth.
	task automatic test_buffer_full();
		configure(16'd3, 16'd6);
		for (int i = 0; i < 9; i++) begin
			key_press((i % 2 == 1) ? 3 : 1, 5);
		end
		hold_key(1'b0, 2);
	endtask

	// Writes to indexes that do not exist must leave both registers alone.
	task automatic test_register_map();
		configure(16'd3, 16'd6);
		write_reg(REG_FIRST_UNUSED, '0);
		write_reg(REG_LAST_INDEX, 16'h0001);
		key_press(1, 2);
		key_press(1, 7);
	endtask

	// Every letter and digit once, with both sides idling a little.
	task automatic test_every_code();
		set_idling(IDLE_BOTH);
		configure(REG_W'($urandom_range(2, 5)), REG_W'($urandom_range(3, 8)));
		for (int i = 0; i < NUM_CODES; i++) begin
			send_symbol(int'(code_len[i]), 16'(code_pattern[i]),
				int'(quiet_limit) + 1 + $urandom_range(0, 3));
		end
	endtask

	// Random phases. Most traffic is well-formed symbols with random content,
	// the rest is raw key noise and symbols whose closing silence falls
	// around the timeout so that they may run into the next one.
	task automatic test_random_traffic();
		idling_t phases [5];
		int first_tick;
		int first_symbol;
		int kind;
		int len;
		phases = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
		foreach (phases[p]) begin
			configure(pick_setting(6), pick_setting(10));
			set_idling(phases[p]);
			first_tick = ticks_sent;
			first_symbol = symbols_decoded;
			while (ticks_sent - first_tick < RANDOM_TICKS / 5
					|| symbols_decoded - first_symbol < MIN_PHASE_SYMBOLS) begin
				kind = $urandom_range(99);
				if (kind < 70) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
					send_symbol(len, 16'($urandom), int'(quiet_limit) + 1 + $urandom_range(0, 3));
				end else if (kind < 85) begin
					hold_key(1'($urandom_range(1)), $urandom_range(1, 12));
				end else begin
					send_symbol($urandom_range(1, 4), 16'($urandom),
						$urandom_range(1, int'(quiet_limit) + 1));
				end
				// Now and then the sender waits for the output to catch up.
				if ($urandom_range(19) == 0) begin
					wait_for_results();
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		string codes;
		int idx;
		int n;
		logic [PATTERN_W-1:0] pat;

		// Build the predictor's table from dot-and-dash text, A to Z, 0 to 9.
		codes = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- .--. ",
			"--.- .-. ... - ..- ...- .-- -..- -.-- --.. ",
			"----- .---- ..--- ...-- ....- ..... -.... --... ---.. ----."};
		idx = 0;
		n = 0;
		pat = '0;
		for (int i = 0; i <= codes.len(); i++) begin
			if (i == codes.len() || codes[i] == " ") begin
				code_len[idx] = EL_CNT_W'(n);
				code_pattern[idx] = pat;
				idx++;
				n = 0;
				pat = '0;
			end else begin
				if (codes[i] == "-") begin
					pat[n] = 1'b1;
				end
				n++;
			end
		end

		set_idling(IDLE_NONE);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_press_length();
		test_timeout_zero();
		test_unmatched_patterns();
		test_buffer_full();
		test_register_map();
		test_every_code();
		test_random_traffic();

		// Drain with the receiver always ready, so any extra symbol shows up.
		set_idling(IDLE_NONE);
		wait_for_results();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_lookup.sv
hw/rtl/morse_key_to_ascii_decoder.sv
tb/sv/testbench.sv
